>>> hw/rtl/bsdf_pkg.sv
// Shared types, constants and fixed-point helpers of the bone SDF smooth union block.
package bsdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALLOFF_MULT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_K        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SDF_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARCHETYPE      = 3'd4;

    // Archetype codes
    localparam logic [1:0] ARCH_CAPSULE     = 2'd0;
    localparam logic [1:0] ARCH_CYLINDER    = 2'd1;
    localparam logic [1:0] ARCH_METABALL    = 2'd2;
    localparam logic [1:0] ARCH_CAPSULE_ALT = 2'd3;

    localparam logic [16:0] ONE_Q   = 17'(1 << FRAC_BITS);
    localparam logic [15:0] HALF_Q  = 16'(1 << (FRAC_BITS - 1));
    localparam logic [31:0] CYL_EPS = 32'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic signed [31:0] RUN_INIT = 32'(999 << FRAC_BITS);
    localparam logic signed [31:0] SAT_HI   = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_LO   = 32'sh80000000;
    localparam logic signed [39:0] SAT_HI40 = 40'sh007FFFFFFF;
    localparam logic signed [39:0] SAT_LO40 = 40'shFF80000000;

    localparam logic [CFG_W-1:0] ASCALE_RST  = 31'd65536;
    localparam logic [CFG_W-1:0] FALLOFF_RST = 31'd65536;
    localparam logic [CFG_W-1:0] BLEND_K_RST = 31'd19661;
    localparam logic [CFG_W-1:0] SDF_SCALE_RST = 31'd65536;

    typedef struct packed {
        logic signed [31:0] voxel_x;
        logic signed [31:0] voxel_y;
        logic signed [31:0] voxel_z;
        logic signed [31:0] bone_pos_x;
        logic signed [31:0] bone_pos_y;
        logic signed [31:0] bone_pos_z;
        logic signed [31:0] bone_len_x;
        logic signed [31:0] bone_len_y;
        logic signed [31:0] bone_len_z;
        logic               last_bone;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] density;
        logic               inside_res;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] adaptive_scale;
        logic [CFG_W-1:0] falloff_multiplier;
        logic [CFG_W-1:0] blend_k;
        logic [CFG_W-1:0] sdf_scale;
        logic [1:0]       archetype;
    } cfg_t;

    // One classified bone, handed from front to back
    typedef struct packed {
        logic signed [33:0] d0;
        logic signed [33:0] d1;
        logic signed [33:0] d2;
        logic signed [31:0] r0;
        logic               meta;
        logic               zcyl;
        logic               last;
    } work_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI40)
            r = SAT_HI;
        else if (x < SAT_LO40)
            r = SAT_LO;
        else
            r = x[31:0];
        return r;
    endfunction

    // Scale a magnitude product back to Q format, restore sign, saturate
    function automatic logic signed [31:0] qscale(input logic [65:0] prod, input logic neg);
        logic [65-FRAC_BITS:0] p;
        logic signed [31:0]    r;
        p = prod[65:FRAC_BITS];
        if (neg) begin
            if (p > (66'd1 << 31))
                r = SAT_LO;
            else
                r = 32'(0 - p[31:0]);
        end
        else begin
            if (p > ((66'd1 << 31) - 66'd1))
                r = SAT_HI;
            else
                r = $signed(p[31:0]);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/bone_sdf_smooth_union.sv
// Top level of the bone SDF smooth union block.
//
// Each input item carries one voxel position and one bone; the block folds
// the bone's capsule, cylinder or metaball distance into a running smooth
// minimum and, on the item marked last_bone, returns one density item
// (0.5 - distance * sdf_scale, Q16.16, saturated) with an inside flag, then
// restarts the running distance at 999.0. The front end classifies each item
// in the cycle it is accepted and places it in a two-entry queue, so up to
// two items are taken while the back end is busy. The back end works on one
// bone at a time with a single shared multiplier. A metaball that lies
// inside its radius adds a 16-step divider and the falloff polynomial, a
// bone within the blend width adds a 16-step divider for the blend weight,
// and the last bone adds the density scale. The 32-step bit-serial square
// root is the largest share of a bone's work. The output register holds a
// finished item while the back end moves on to the next bone. Configuration
// registers are written through a plain write port and must only be
// changed while no item is in flight.
module bone_sdf_smooth_union
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bsdf_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output bsdf_pkg::out_item_t               out_data,
    input  logic                              cfg_wr_en,
    input  logic [bsdf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsdf_pkg::CFG_W-1:0]        cfg_wdata
);

    bsdf_pkg::cfg_t  cfg_reg, cfg_next;
    bsdf_pkg::work_t fe_work, q_data;
    logic            q_full, q_avail, q_pop, push;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // config write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bsdf_pkg::REG_ADAPTIVE_SCALE: cfg_next.adaptive_scale     = cfg_wdata;
                bsdf_pkg::REG_FALLOFF_MULT:   cfg_next.falloff_multiplier = cfg_wdata;
                bsdf_pkg::REG_BLEND_K:        cfg_next.blend_k            = cfg_wdata;
                bsdf_pkg::REG_SDF_SCALE:      cfg_next.sdf_scale          = cfg_wdata;
                bsdf_pkg::REG_ARCHETYPE:      cfg_next.archetype          = cfg_wdata[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adaptive_scale     <= bsdf_pkg::ASCALE_RST;
            cfg_reg.falloff_multiplier <= bsdf_pkg::FALLOFF_RST;
            cfg_reg.blend_k            <= bsdf_pkg::BLEND_K_RST;
            cfg_reg.sdf_scale          <= bsdf_pkg::SDF_SCALE_RST;
            cfg_reg.archetype          <= bsdf_pkg::ARCH_CAPSULE;
        end
        else
            cfg_reg <= cfg_next;
    end

    bsdf_front u_front
    (
        .item      (in_data),
        .archetype (cfg_reg.archetype),
        .work      (fe_work)
    );

    bsdf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (fe_work),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_data)
    );

    bsdf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_avail   (q_avail),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/bsdf_front.sv
// Front end: turns one input item into a classified bone work entry.
module bsdf_front
(
    input  bsdf_pkg::in_item_t item,
    input  logic [1:0]         archetype,
    output bsdf_pkg::work_t    work
);

    logic signed [32:0] dx, dy, dz, t;
    logic [31:0]        mx, my, mz, mlen;
    logic [1:0]         ax;
    logic signed [31:0] len, lhalf, lo, hi, c;
    logic [30:0]        half;
    logic signed [33:0] tm, tc, adj, sum, rq;
    logic               meta;

    assign dx = 33'(item.voxel_x) - 33'(item.bone_pos_x);
    assign dy = 33'(item.voxel_y) - 33'(item.bone_pos_y);
    assign dz = 33'(item.voxel_z) - 33'(item.bone_pos_z);

    assign mx = item.bone_len_x[31] ? 32'(-33'(item.bone_len_x)) : 32'(item.bone_len_x);
    assign my = item.bone_len_y[31] ? 32'(-33'(item.bone_len_y)) : 32'(item.bone_len_y);
    assign mz = item.bone_len_z[31] ? 32'(-33'(item.bone_len_z)) : 32'(item.bone_len_z);

    assign meta = (archetype == bsdf_pkg::ARCH_METABALL);

    always_comb
    begin
        // dominant axis, ties go Y, then X, then Z
        if (my >= mx && my >= mz)
            ax = 2'd1;
        else if (mx >= mz)
            ax = 2'd0;
        else
            ax = 2'd2;

        case (ax)
            2'd0:
            begin
                len = item.bone_len_x; mlen = mx; t = dx;
            end
            2'd1:
            begin
                len = item.bone_len_y; mlen = my; t = dy;
            end
            default:
            begin
                len = item.bone_len_z; mlen = mz; t = dz;
            end
        endcase

        half  = mlen[31:1];
        lhalf = len[31] ? -$signed({1'b0, half}) : $signed({1'b0, half});
        tm    = 34'(t) - 34'(lhalf);

        lo = len[31] ? len : 32'sd0;
        hi = len[31] ? 32'sd0 : len;
        if (t < 33'(lo))
            c = lo;
        else if (t > 33'(hi))
            c = hi;
        else
            c = t[31:0];
        tc  = 34'(t) - 34'(c);
        adj = meta ? tm : tc;

        // radius seed: sum / 4 truncated toward zero
        sum = 34'(item.bone_len_x) + 34'(item.bone_len_y) + 34'(item.bone_len_z);
        rq  = sum[33] ? ((sum + 34'sd3) >>> 2) : (sum >>> 2);

        work.d0   = (ax == 2'd0) ? adj : 34'(dx);
        work.d1   = (ax == 2'd1) ? adj : 34'(dy);
        work.d2   = (ax == 2'd2) ? adj : 34'(dz);
        work.r0   = rq[31:0];
        work.meta = meta;
        work.zcyl = (archetype == bsdf_pkg::ARCH_CYLINDER) && (mlen < bsdf_pkg::CYL_EPS);
        work.last = item.last_bone;
    end

endmodule

>>> hw/rtl/bsdf_queue.sv
// Two-entry queue of work entries between front and back.
module bsdf_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bsdf_pkg::work_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output bsdf_pkg::work_t pop_data
);

    bsdf_pkg::work_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign avail    = (count_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/bsdf_back.sv
// Back end: sequencer with one shared multiplier, serial root and serial divider.
module bsdf_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  bsdf_pkg::cfg_t      cfg,
    input  logic                q_avail,
    input  bsdf_pkg::work_t     q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output bsdf_pkg::out_item_t out_data
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RAD1 = 5'd1;
    localparam logic [4:0] ST_RAD2 = 5'd2;
    localparam logic [4:0] ST_SQ0  = 5'd3;
    localparam logic [4:0] ST_SQ1  = 5'd4;
    localparam logic [4:0] ST_SQ2  = 5'd5;
    localparam logic [4:0] ST_SQRT = 5'd6;
    localparam logic [4:0] ST_DIST = 5'd7;
    localparam logic [4:0] ST_BONE = 5'd8;
    localparam logic [4:0] ST_MDIV = 5'd9;
    localparam logic [4:0] ST_MN   = 5'd10;
    localparam logic [4:0] ST_MV   = 5'd11;
    localparam logic [4:0] ST_MB   = 5'd12;
    localparam logic [4:0] ST_SM   = 5'd13;
    localparam logic [4:0] ST_SDIV = 5'd14;
    localparam logic [4:0] ST_HSET = 5'd15;
    localparam logic [4:0] ST_KH   = 5'd16;
    localparam logic [4:0] ST_T1   = 5'd17;
    localparam logic [4:0] ST_T2   = 5'd18;
    localparam logic [4:0] ST_SUM  = 5'd19;
    localparam logic [4:0] ST_SCL  = 5'd20;
    localparam logic [4:0] ST_OUT  = 5'd21;

    logic [4:0]         state_reg, state_next;
    logic [29:0]        x0_reg, x0_next, x1_reg, x1_next, x2_reg, x2_next;
    logic [2:0]         sh_reg, sh_next;
    logic signed [31:0] r0_reg, r0_next, rad_reg, rad_next, rr_reg, rr_next;
    logic               meta_reg, meta_next, zcyl_reg, zcyl_next, last_reg, last_next;
    logic [63:0]        acc_reg, acc_next, root_reg, root_next, bit_reg, bit_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [35:0]        dist_reg, dist_next;
    logic signed [31:0] bone_reg, bone_next, tmp_reg, tmp_next;
    logic [33:0]        rem_reg, rem_next;
    logic [32:0]        den_reg, den_next;
    logic [15:0]        quo_reg, quo_next;
    logic [16:0]        om_reg, om_next, h_reg, h_next;
    logic signed [32:0] e_reg, e_next;
    logic signed [31:0] kh_reg, kh_next, t1_reg, t1_next, run_reg, run_next;
    logic               out_valid_reg, out_valid_next;
    bsdf_pkg::out_item_t out_data_reg, out_data_next;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic [32:0]        ma, mb;
    logic [65:0]        prod;
    logic signed [31:0] mq;

    // helpers
    logic [33:0]        m0, m1, m2, mmax;
    logic [2:0]         s;
    logic [63:0]        rsum;
    logic [33:0]        rem2;
    logic               ge;
    logic signed [32:0] kq;
    logic [31:0]        rr_mag;
    logic signed [39:0] dist40;
    logic signed [39:0] dens40;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_RAD1:
            begin
                mul_a = 34'(r0_reg); mul_b = $signed({3'b0, cfg.adaptive_scale});
            end
            ST_RAD2:
            begin
                mul_a = 34'(rad_reg); mul_b = $signed({3'b0, cfg.falloff_multiplier});
            end
            ST_SQ0:
            begin
                mul_a = $signed({4'b0, x0_reg}); mul_b = $signed({4'b0, x0_reg});
            end
            ST_SQ1:
            begin
                mul_a = $signed({4'b0, x1_reg}); mul_b = $signed({4'b0, x1_reg});
            end
            ST_SQ2:
            begin
                mul_a = $signed({4'b0, x2_reg}); mul_b = $signed({4'b0, x2_reg});
            end
            ST_MN:
            begin
                mul_a = $signed({18'b0, quo_reg}); mul_b = $signed({18'b0, quo_reg});
            end
            ST_MV:
            begin
                mul_a = $signed({17'b0, om_reg}); mul_b = $signed({17'b0, om_reg});
            end
            ST_MB:
            begin
                mul_a = 34'(tmp_reg); mul_b = 34'(rr_reg);
            end
            ST_KH:
            begin
                mul_a = $signed({3'b0, cfg.blend_k}); mul_b = $signed({17'b0, h_reg});
            end
            ST_T1:
            begin
                mul_a = $signed({17'b0, h_reg}); mul_b = 34'(run_reg) - 34'(bone_reg);
            end
            ST_T2:
            begin
                mul_a = 34'(kh_reg);
                mul_b = $signed({17'b0, 17'(bsdf_pkg::ONE_Q - h_reg)});
            end
            ST_SCL:
            begin
                mul_a = 34'(tmp_reg); mul_b = $signed({3'b0, cfg.sdf_scale});
            end
            default:
            begin
                mul_a = '0; mul_b = '0;
            end
        endcase
        ma   = mul_a[33] ? 33'(-mul_a) : mul_a[32:0];
        mb   = mul_b[33] ? 33'(-mul_b) : mul_b[32:0];
        prod = 66'(ma) * 66'(mb);
        mq   = bsdf_pkg::qscale(prod, mul_a[33] ^ mul_b[33]);
    end

    always_comb
    begin
        state_next = state_reg;
        x0_next = x0_reg; x1_next = x1_reg; x2_next = x2_reg; sh_next = sh_reg;
        r0_next = r0_reg; rad_next = rad_reg; rr_next = rr_reg;
        meta_next = meta_reg; zcyl_next = zcyl_reg; last_next = last_reg;
        acc_next = acc_reg; root_next = root_reg; bit_next = bit_reg; cnt_next = cnt_reg;
        dist_next = dist_reg; bone_next = bone_reg; tmp_next = tmp_reg;
        rem_next = rem_reg; den_next = den_reg; quo_next = quo_reg;
        om_next = om_reg; h_next = h_reg; e_next = e_reg;
        kh_next = kh_reg; t1_next = t1_reg; run_next = run_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        q_pop = 1'b0;

        m0 = q_data.d0[33] ? 34'(-q_data.d0) : q_data.d0;
        m1 = q_data.d1[33] ? 34'(-q_data.d1) : q_data.d1;
        m2 = q_data.d2[33] ? 34'(-q_data.d2) : q_data.d2;
        mmax = m0;
        if (m1 > mmax)
            mmax = m1;
        if (m2 > mmax)
            mmax = m2;
        if (mmax[33])
            s = 3'd4;
        else if (mmax[32])
            s = 3'd3;
        else if (mmax[31])
            s = 3'd2;
        else if (mmax[30])
            s = 3'd1;
        else
            s = 3'd0;

        rsum   = root_reg + bit_reg;
        rem2   = {rem_reg[32:0], 1'b0};
        ge     = rem2 >= {1'b0, den_reg};
        kq     = $signed({2'b0, cfg.blend_k});
        rr_mag = rr_reg[31] ? 32'(-33'(rr_reg)) : 32'(rr_reg);
        dist40 = $signed({4'b0, dist_reg});
        dens40 = 40'(bsdf_pkg::HALF_Q) - 40'(mq);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop     = 1'b1;
                    x0_next   = 30'(m0 >> s);
                    x1_next   = 30'(m1 >> s);
                    x2_next   = 30'(m2 >> s);
                    sh_next   = s;
                    r0_next   = q_data.r0;
                    meta_next = q_data.meta;
                    zcyl_next = q_data.zcyl;
                    last_next = q_data.last;
                    acc_next  = '0;
                    state_next = ST_RAD1;
                end
            end
            ST_RAD1:
            begin
                rad_next = mq; state_next = ST_RAD2;
            end
            ST_RAD2:
            begin
                rad_next = mq; state_next = ST_SQ0;
            end
            ST_SQ0:
            begin
                acc_next = acc_reg + 64'(prod[59:0]); state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                acc_next = acc_reg + 64'(prod[59:0]); state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                acc_next  = acc_reg + 64'(prod[59:0]);
                root_next = '0;
                bit_next  = 64'd1 << 62;
                cnt_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (acc_reg >= rsum)
                begin
                    acc_next  = acc_reg - rsum;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = ST_DIST;
            end
            ST_DIST:
            begin
                dist_next  = 36'(root_reg[31:0]) << sh_reg;
                rr_next    = bsdf_pkg::sat32(40'(rad_reg) <<< 1);
                state_next = ST_BONE;
            end
            ST_BONE:
            begin
                if (!meta_reg)
                begin
                    bone_next  = zcyl_reg ? 32'sd0 : bsdf_pkg::sat32(dist40 - 40'(rad_reg));
                    state_next = ST_SM;
                end
                else if (dist_reg >= 36'(rr_mag))
                begin
                    bone_next  = bsdf_pkg::sat32(dist40 - 40'(rr_reg));
                    state_next = ST_SM;
                end
                else
                begin
                    rem_next = {2'b0, dist_reg[31:0]};
                    den_next = {1'b0, rr_mag};
                    quo_next = '0;
                    cnt_next = '0;
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                rem_next = ge ? rem2 - {1'b0, den_reg} : rem2;
                quo_next = {quo_reg[14:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = ST_MN;
            end
            ST_MN:
            begin
                om_next = bsdf_pkg::ONE_Q - mq[16:0]; state_next = ST_MV;
            end
            ST_MV:
            begin
                tmp_next = mq; state_next = ST_MB;
            end
            ST_MB:
            begin
                bone_next = bsdf_pkg::sat32(40'sd0 - 40'(mq)); state_next = ST_SM;
            end
            ST_SM:
            begin
                e_next = 33'(bone_reg) - 33'(run_reg);
                if ((33'(bone_reg) - 33'(run_reg)) >= kq)
                begin
                    h_next = bsdf_pkg::ONE_Q; state_next = ST_KH;
                end
                else if ((33'(bone_reg) - 33'(run_reg)) <= (33'sd0 - kq))
                begin
                    h_next = '0; state_next = ST_KH;
                end
                else
                begin
                    state_next = ST_SDIV;
                    cnt_next   = '0;
                    quo_next   = '0;
                    den_next   = {1'b0, cfg.blend_k, 1'b0};
                    rem_next   = (33'(bone_reg) - 33'(run_reg)) < 33'sd0
                               ? {2'b0, 32'(33'(run_reg) - 33'(bone_reg))}
                               : {2'b0, 32'(33'(bone_reg) - 33'(run_reg))};
                end
            end
            ST_SDIV:
            begin
                rem_next = ge ? rem2 - {1'b0, den_reg} : rem2;
                quo_next = {quo_reg[14:0], ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                    state_next = ST_HSET;
            end
            ST_HSET:
            begin
                h_next = e_reg[32] ? 17'(bsdf_pkg::HALF_Q) - 17'(quo_reg)
                                   : 17'(bsdf_pkg::HALF_Q) + 17'(quo_reg);
                state_next = ST_KH;
            end
            ST_KH:
            begin
                kh_next = mq; state_next = ST_T1;
            end
            ST_T1:
            begin
                t1_next = mq; state_next = ST_T2;
            end
            ST_T2:
            begin
                tmp_next   = bsdf_pkg::sat32(40'(bone_reg) + 40'(t1_reg) - 40'(mq));
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (last_reg)
                    state_next = ST_SCL;
                else
                begin
                    run_next   = tmp_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SCL:
            begin
                tmp_next = bsdf_pkg::sat32(dens40); state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.density    = tmp_reg;
                    out_data_next.inside_res = tmp_reg > $signed({16'b0, bsdf_pkg::HALF_Q});
                    run_next   = bsdf_pkg::RUN_INIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next; x1_reg <= x1_next; x2_reg <= x2_next; sh_reg <= sh_next;
        r0_reg <= r0_next; rad_reg <= rad_next; rr_reg <= rr_next;
        meta_reg <= meta_next; zcyl_reg <= zcyl_next; last_reg <= last_next;
        acc_reg <= acc_next; root_reg <= root_next; bit_reg <= bit_next; cnt_reg <= cnt_next;
        dist_reg <= dist_next; bone_reg <= bone_next; tmp_reg <= tmp_next;
        rem_reg <= rem_next; den_reg <= den_next; quo_reg <= quo_next;
        om_reg <= om_next; h_reg <= h_next; e_reg <= e_next;
        kh_reg <= kh_next; t1_reg <= t1_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= bsdf_pkg::RUN_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/bsdf_checker.sv
// Port-level checker for the bone SDF smooth union block, with its bind.
module bsdf_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input bsdf_pkg::out_item_t out_data
);

    // inside flag agrees with the density it travels with
    a_inside_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.inside_res ==
                       (out_data.density > $signed({16'b0, bsdf_pkg::HALF_Q}))))
        else $error("inside flag disagrees with density");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered right after reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("stalled result changed");

endmodule

bind bone_sdf_smooth_union bsdf_checker u_checker (.*);

>>> tb/sv/tb_bone_sdf_smooth_union.sv
// Testbench for bone_sdf_smooth_union: random and directed bones checked against a predictor.
module tb_bone_sdf_smooth_union;
    import bsdf_pkg::*;

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ADAPTIVE_SCALE;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Bones waiting to be sent, and densities waiting to come back
    in_item_t bone_q[$];
    out_item_t density_q[$];
    int mismatch_cnt = 0;
    int send_gap = 0;
    bit idle_on = 1'b1;

    // Predictor state: registers and the running smooth-union distance
    cfg_t cur_cfg;
    longint run_dist;

    bone_sdf_smooth_union dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    // ---------------- fixed-point predictor ----------------

    function automatic longint clamp32(longint x);
        if (x > 64'sh7FFFFFFF)
            return 64'sh7FFFFFFF;
        if (x < -64'sh80000000)
            return -64'sh80000000;
        return x;
    endfunction

    function automatic longint unsigned magn(longint x);
        return (x < 0) ? longint'(0) - x : x;
    endfunction

    // Product of magnitudes, truncated, sign restored, saturated
    function automatic longint qmul(longint a, longint b);
        logic [127:0] prod;
        longint unsigned r;
        bit neg;
        neg = (a < 0) != (b < 0);
        prod = 128'(magn(a)) * 128'(magn(b));
        prod = prod >> FRAC_BITS;
        if (prod > (128'd1 << 62))
            r = 64'd1 << 62;
        else
            r = prod[63:0];
        return clamp32(neg ? -longint'(r) : longint'(r));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vector length with pre-shift to keep the squares in range
    function automatic longint vec_len(longint a, longint b, longint c);
        longint unsigned x, y, z, m;
        int s = 0;
        x = magn(a);
        y = magn(b);
        z = magn(c);
        m = x;
        if (y > m)
            m = y;
        if (z > m)
            m = z;
        while ((m >> s) >= (64'd1 << 30))
            s++;
        x = x >> s;
        y = y >> s;
        z = z >> s;
        return longint'(int_sqrt(x * x + y * y + z * z) << s);
    endfunction

    function automatic longint bone_dist(in_item_t it);
        longint p[3], b[3], l[3], d[3];
        longint r, len, cdist, rr, lo, hi, t, c;
        longint unsigned den, rem, u, n, om, v;
        int ax;
        p = '{it.voxel_x, it.voxel_y, it.voxel_z};
        b = '{it.bone_pos_x, it.bone_pos_y, it.bone_pos_z};
        l = '{it.bone_len_x, it.bone_len_y, it.bone_len_z};
        r = clamp32((l[0] + l[1] + l[2]) / 4);
        r = qmul(r, longint'(cur_cfg.adaptive_scale));
        r = qmul(r, longint'(cur_cfg.falloff_multiplier));
        // Dominant axis; ties go Y, then X, then Z
        if (magn(l[1]) >= magn(l[0]) && magn(l[1]) >= magn(l[2]))
            ax = 1;
        else if (magn(l[0]) >= magn(l[2]))
            ax = 0;
        else
            ax = 2;
        len = l[ax];
        for (int i = 0; i < 3; i++)
            d[i] = p[i] - b[i];
        if (cur_cfg.archetype == ARCH_METABALL)
        begin
            d[ax] = d[ax] - len / 2;
            cdist = vec_len(d[0], d[1], d[2]);
            rr = clamp32(2 * r);
            den = magn(rr);
            if (cdist >= 0 && unsigned'(cdist) >= den)
                return clamp32(cdist - rr);
            rem = cdist;
            u = 0;
            for (int i = 0; i < FRAC_BITS; i++)
            begin
                rem = rem << 1;
                u = u << 1;
                if (rem >= den)
                begin
                    rem = rem - den;
                    u = u | 1;
                end
            end
            n = (u * u) >> FRAC_BITS;
            om = ONE - n;
            v = (om * om) >> FRAC_BITS;
            return clamp32(-qmul(longint'(v), rr));
        end
        // Capsule and cylinder: clamp onto the axis-aligned segment
        lo = (len < 0) ? len : 0;
        hi = (len < 0) ? 0 : len;
        if (cur_cfg.archetype == ARCH_CYLINDER && magn(len) < 64'(CYL_EPS))
            return 0;
        t = d[ax];
        c = (t < lo) ? lo : ((t > hi) ? hi : t);
        d[ax] = t - c;
        return clamp32(vec_len(d[0], d[1], d[2]) - r);
    endfunction

    // Polynomial smooth minimum of the running distance and one bone
    function automatic longint smooth_fold(longint run, longint bone);
        longint k, e, h, kh, q;
        k = longint'(cur_cfg.blend_k);
        e = bone - run;
        if (e >= k)
            h = ONE;
        else if (e <= -k)
            h = 0;
        else
        begin
            q = longint'((magn(e) << FRAC_BITS) / unsigned'(2 * k));
            h = (e < 0) ? HALF - q : HALF + q;
        end
        kh = qmul(k, h);
        return clamp32(bone + qmul(h, run - bone) - qmul(kh, ONE - h));
    endfunction

    // Fold one accepted bone; a last bone yields one expected density
    task automatic fold_bone(in_item_t it);
        longint dens;
        out_item_t res;
        run_dist = smooth_fold(run_dist, bone_dist(it));
        if (it.last_bone)
        begin
            dens = HALF - qmul(run_dist, longint'(cur_cfg.sdf_scale));
            dens = clamp32(dens);
            res.density = dens[31:0];
            res.inside_res = dens > HALF;
            density_q.push_back(res);
            run_dist = longint'(RUN_INIT);
        end
    endtask

    // ---------------- idling ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                fold_bone(in_data);
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (bone_q.size() > 0)
                begin
                    in_data <= bone_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (density_q.size() == 0)
                begin
                    $display("%0t: unexpected density %h inside %b", $time,
                             out_data.density, out_data.inside_res);
                    mismatch_cnt++;
                end
                else if (out_data !== density_q[0])
                begin
                    $display("%0t: expected density %h inside %b, got density %h inside %b",
                             $time, density_q[0].density, density_q[0].inside_res,
                             out_data.density, out_data.inside_res);
                    mismatch_cnt++;
                    void'(density_q.pop_front());
                end
                else
                    void'(density_q.pop_front());
            end
            out_stall <= (pick_gap() > 0);
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [31:0] rnd_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h0;
                1: return 32'h1;
                2: return 32'hFFFFFFFF;
                3: return 32'h7FFFFFFF;
                default: return 32'h80000000;
            endcase
        end
        if (r < 20)
            return $urandom;
        return $urandom_range(0, (1 << 22) - 1) - (1 << 21);
    endfunction

    function automatic logic [31:0] near(logic [31:0] base);
        return base + ($urandom_range(0, (1 << 19) - 1) - (1 << 18));
    endfunction

    function automatic logic [31:0] rnd_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, (1 << 20) - 1) - (1 << 19);
        return rnd_coord();
    endfunction

    task automatic add_bone(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                            logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                            logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic last);
        in_item_t it;
        it.voxel_x = vx;
        it.voxel_y = vy;
        it.voxel_z = vz;
        it.bone_pos_x = bx;
        it.bone_pos_y = by;
        it.bone_pos_z = bz;
        it.bone_len_x = lx;
        it.bone_len_y = ly;
        it.bone_len_z = lz;
        it.last_bone = last;
        bone_q.push_back(it);
    endtask

    // One voxel against a short chain of bones, mostly placed close to it
    task automatic add_voxel(output int cnt);
        logic [31:0] vx, vy, vz, lx, ly, lz, a;
        int nb, mode;
        vx = rnd_coord();
        vy = rnd_coord();
        vz = rnd_coord();
        nb = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
        cnt = nb;
        for (int i = 0; i < nb; i++)
        begin
            mode = $urandom_range(0, 99);
            a = rnd_len();
            lx = rnd_len();
            ly = rnd_len();
            lz = rnd_len();
            if (mode < 8)
            begin
                lx = 0;
                ly = 0;
                lz = 0;
            end
            else if (mode < 16)
            begin
                // below the degenerate-cylinder threshold
                lx = $urandom_range(0, 100) - 50;
                ly = $urandom_range(0, 100) - 50;
                lz = $urandom_range(0, 100) - 50;
            end
            else if (mode < 22)
            begin
                lx = a;
                ly = -a;
            end
            else if (mode < 28)
            begin
                lx = a;
                lz = a;
                ly = 0;
            end
            else if (mode < 34)
            begin
                ly = a;
                lz = -a;
                lx = 0;
            end
            if ($urandom_range(0, 9) < 8)
                add_bone(vx, vy, vz, near(vx), near(vy), near(vz), lx, ly, lz, i == nb - 1);
            else
                add_bone(vx, vy, vz, rnd_coord(), rnd_coord(), rnd_coord(), lx, ly, lz,
                         i == nb - 1);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ADAPTIVE_SCALE: cur_cfg.adaptive_scale = val;
            REG_FALLOFF_MULT:   cur_cfg.falloff_multiplier = val;
            REG_BLEND_K:        cur_cfg.blend_k = val;
            REG_SDF_SCALE:      cur_cfg.sdf_scale = val;
            default:            cur_cfg.archetype = val[1:0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (bone_q.size() != 0 || in_valid || density_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] rnd_scale();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom;
        if (r == 1)
            return 0;
        return $urandom_range(1 << 14, 1 << 18);
    endfunction

    initial
    begin
        int sent;
        int cnt;
        cur_cfg.adaptive_scale = ASCALE_RST;
        cur_cfg.falloff_multiplier = FALLOFF_RST;
        cur_cfg.blend_k = BLEND_K_RST;
        cur_cfg.sdf_scale = SDF_SCALE_RST;
        cur_cfg.archetype = ARCH_CAPSULE;
        run_dist = longint'(RUN_INIT);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, zero-length axis, axis ties, blending chains
        add_bone(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        add_bone('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                 '1 >> 1, '1 >> 1, '1 >> 1, 1'b1);
        add_bone(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
        add_bone(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b1);
        add_bone(32'h30000, 32'h10000, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        add_bone(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h20000, 32'h20000, 0, 1'b1);
        add_bone(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'hFFFE0000, 0, 32'h20000,
                 1'b1);
        add_bone(32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0, 32'h20000, 32'hFFFE0000,
                 1'b1);
        add_bone(32'h8000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 1'b1);
        add_bone(32'h10000, 0, 0, 0, 0, 0, 32'h20000, 0, 0, 1'b0);
        add_bone(32'h10000, 0, 0, 32'h1000, 0, 0, 0, 32'h20000, 0, 1'b0);
        add_bone(32'h10000, 0, 0, 0, 32'h800, 0, 0, 0, 32'h20000, 1'b1);
        add_bone(0, 0, 0, 0, 0, 0, 32'hFFFC0000, 32'h10000, 0, 1'b1);
        add_bone(32'h50000, 32'h50000, 32'h50000, 32'h50000, 32'h50000, 32'h50000,
                 32'h30, 32'h10, 32'h20, 1'b1);
        sent = 0;
        while (sent < 190)
        begin
            add_voxel(cnt);
            sent += cnt;
        end
        wait_drained();

        for (int ph = 1; ph <= 9; ph++)
        begin
            idle_on = (ph % 3) != 0;
            if (ph == 1)
            begin
                write_reg(REG_ADAPTIVE_SCALE, '1);
                write_reg(REG_FALLOFF_MULT, '1);
                write_reg(REG_BLEND_K, '1);
                write_reg(REG_SDF_SCALE, '1);
            end
            else if (ph == 2)
            begin
                write_reg(REG_ADAPTIVE_SCALE, 0);
                write_reg(REG_FALLOFF_MULT, 0);
                write_reg(REG_BLEND_K, 1);
                write_reg(REG_SDF_SCALE, 0);
            end
            else
            begin
                write_reg(REG_ADAPTIVE_SCALE, rnd_scale());
                write_reg(REG_FALLOFF_MULT, rnd_scale());
                write_reg(REG_BLEND_K, ($urandom_range(0, 9) == 0) ? $urandom :
                          $urandom_range(1, 1 << 18));
                write_reg(REG_SDF_SCALE, rnd_scale());
            end
            write_reg(REG_ARCHETYPE, CFG_W'(ph % 4));
            sent = 0;
            while (sent < 190)
            begin
                // occasional noise bone, never left as the phase's last item
                if ($urandom_range(0, 9) == 0)
                begin
                    add_bone($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, 1'b1);
                    sent++;
                end
                add_voxel(cnt);
                sent += cnt;
            end
            wait_drained();
        end

        if (mismatch_cnt == 0)
            $display("bone_sdf_smooth_union test passed");
        else
            $display("bone_sdf_smooth_union test failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("bone_sdf_smooth_union test failed");
        $finish;
    end

endmodule
